// ===== rtl/rpn_pkg.sv =====
package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int DEF_STACK_DEPTH = 64;

  // token kinds (in_tuser)
  localparam logic [1:0] CMD_DIGIT   = 2'd0;
  localparam logic [1:0] CMD_OPER    = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;
  localparam logic [1:0] CMD_INVALID = 2'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_COUNT     = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // controller -> datapath
  typedef struct packed {
    logic       push;       // push digit
    logic       rd_left;    // read left operand from stack memory
    logic       alu_wr;     // write add/sub/mul result, pop one
    logic       div_start;
    logic       div_wr;     // write quotient, pop one
    logic       set_err;
    logic [2:0] err_code;
    logic [1:0] op_sel;
    logic       finish;     // end token: emit result, clear stack
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err_active;
    logic depth_ge2;
    logic depth_full;
    logic r_zero;
    logic div_done;
    logic out_valid;
  } dp_sts_t;

endpackage

// ===== rtl/rpn_div.sv =====
module rpn_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rpn_pkg::DATA_W-1:0]  dividend,
  input  logic [rpn_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [rpn_pkg::DATA_W-1:0]  quotient
);
  import rpn_pkg::*;

  localparam int CW = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic [DATA_W:0]   trial;

  assign trial = {rem_r, quo_r[DATA_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      // work on magnitudes, fix the sign at the end
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rem_nxt  = '0;
      quo_nxt  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      den_nxt  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DATA_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== rtl/rpn_dpath.sv =====
module rpn_dpath #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rpn_pkg::dp_cmd_t            cmd,
  input  logic [3:0]                  digit,
  input  logic                        out_tready,
  output rpn_pkg::dp_sts_t            sts,
  output logic                        out_tvalid,
  output logic [rpn_pkg::DATA_W-1:0]  out_result,
  output logic [2:0]                  out_status
);
  import rpn_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  // top of stack lives in tos_r; entries below it live in mem
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] tos_r, tos_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [2:0]        err_r, err_nxt;
  logic              ov_r, ov_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [2:0]        stat_r, stat_nxt;
  logic [DW-1:0]     wr_ptr, rd_ptr;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] div_q;
  logic              div_done;

  assign wr_ptr = depth_r - DW'(1);
  assign rd_ptr = depth_r - DW'(2);

  always_ff @(posedge clk) begin
    if (cmd.push && depth_r != '0) mem[wr_ptr[AW-1:0]] <= tos_r;
    if (cmd.rd_left) rdata_r <= mem[rd_ptr[AW-1:0]];
  end

  always_comb begin
    case (cmd.op_sel)
      OP_ADD:  alu_res = rdata_r + tos_r;
      OP_SUB:  alu_res = rdata_r - tos_r;
      OP_MUL:  alu_res = DATA_W'(rdata_r * tos_r);
      default: alu_res = rdata_r;
    endcase
  end

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rdata_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    tos_nxt   = tos_r;
    depth_nxt = depth_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    if (out_tready) ov_nxt = 1'b0;
    if (cmd.push) begin
      tos_nxt   = DATA_W'(digit);
      depth_nxt = depth_r + DW'(1);
    end
    if (cmd.alu_wr) begin
      tos_nxt   = alu_res;
      depth_nxt = depth_r - DW'(1);
    end
    if (cmd.div_wr) begin
      tos_nxt   = div_q;
      depth_nxt = depth_r - DW'(1);
    end
    if (cmd.set_err) err_nxt = cmd.err_code;
    if (cmd.finish) begin
      ov_nxt    = 1'b1;
      depth_nxt = '0;
      err_nxt   = ST_OK;
      if (err_r != ST_OK) begin
        stat_nxt = err_r;
        res_nxt  = '0;
      end else if (depth_r == DW'(1)) begin
        stat_nxt = ST_OK;
        res_nxt  = tos_r;
      end else begin
        stat_nxt = ST_COUNT;
        res_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= ST_OK;
      ov_r    <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
    tos_r  <= tos_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
  end

  assign sts.err_active = (err_r != ST_OK);
  assign sts.depth_ge2  = (depth_r >= DW'(2));
  assign sts.depth_full = (depth_r == DW'(STACK_DEPTH));
  assign sts.r_zero     = (tos_r == '0);
  assign sts.div_done   = div_done;
  assign sts.out_valid  = ov_r;

  assign out_tvalid = ov_r;
  assign out_result = res_r;
  assign out_status = stat_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> depth_r != DW'(STACK_DEPTH))
    else $error("push onto full stack");

  a_pop_two: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alu_wr || cmd.div_wr || cmd.div_start) |-> depth_r >= DW'(2))
    else $error("operator with fewer than two operands");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (ov_r && depth_r == '0 && err_r == ST_OK))
    else $error("end token did not emit and clear");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && stat_r != ST_OK) |-> res_r == '0)
    else $error("nonzero result with error status");

endmodule

// ===== rtl/rpn_ctrl.sv =====
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [1:0]        in_cmd,
  input  logic [3:0]        in_digit,
  input  logic [1:0]        in_op,
  input  logic              out_tready,
  input  rpn_pkg::dp_sts_t  sts,
  output logic              in_tready,
  output rpn_pkg::dp_cmd_t  cmd
);
  import rpn_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIVW = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE) && (!sts.out_valid || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op_sel = op_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_END) begin
            cmd.finish = 1'b1;
          end else if (!sts.err_active) begin
            case (in_cmd)
              CMD_DIGIT: begin
                if (in_digit > DIGIT_MAX) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_INVALID;
                end else if (sts.depth_full) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_OVERFLOW;
                end else begin
                  cmd.push = 1'b1;
                end
              end
              CMD_OPER: begin
                if (!sts.depth_ge2) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_UNDERFLOW;
                end else begin
                  cmd.rd_left = 1'b1;
                  op_nxt      = in_op;
                  state_nxt   = S_EXEC;
                end
              end
              default: begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_INVALID;
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        // left operand now in the read register, right operand is top of stack
        if (op_r != OP_DIV) begin
          cmd.alu_wr = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.r_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIV_ZERO;
          state_nxt    = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r <= op_nxt;
  end

  a_div_path: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == S_DIVW)
    else $error("divider started outside divide wait");

  a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_left |=> state_r == S_EXEC)
    else $error("operand read not followed by execute");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIVW)
    else $error("divider done outside divide wait");

endmodule

// ===== rtl/rpn_stack_evaluator_core.sv =====
// Reverse Polish integer evaluator. Each input word is one token: in_tuser
// carries the kind (digit, operator, end, invalid), in_tdata the digit value
// and operator code. Tokens are taken one at a time. A digit, an invalid
// token, an end token, an operator with too few operands or any token after
// an error is handled in the idle state alone; add, subtract and multiply
// read the left operand from stack memory, then execute; a divide by zero
// ends at the execute step; any other divide then runs the radix-2
// iterative divider (operand read, start, 32 steps, write-back). The end
// token emits one output word with the remaining value and a status, then
// clears the stack. While an output word is pending and out_tready is low,
// no token of any kind is taken.
// Operands are 32-bit two's complement, wrapping. The top of stack is held
// in a register and deeper entries in a STACK_DEPTH-entry memory; no
// clearing pass is needed after reset.
module rpn_stack_evaluator_core #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] digit_value, [5:4] operator_code, [7:6] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value (signed)
  output logic [2:0]  out_tuser   // [2:0] status
);
  import rpn_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rpn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_digit   (in_tdata[3:0]),
    .in_op      (in_tdata[5:4]),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .digit      (in_tdata[3:0]),
    .out_tready (out_tready),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_result (out_tdata),
    .out_status (out_tuser)
  );

endmodule

// ===== bench/rpn_stack_evaluator_core_test.sv =====
`timescale 1ns / 1ps

module rpn_stack_evaluator_core_test;
  import rpn_pkg::*;

  localparam int STACK_N   = DEF_STACK_DEPTH;
  localparam int SAW       = $clog2(STACK_N);
  localparam int TOKEN_GOAL = 1050;

  typedef struct packed {
    logic [31:0] val;
    logic [2:0]  st;
  } answer_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  dig;
    logic [1:0]  opc;
    logic        pin;   // expected answer typed in below
    logic [31:0] val;
    logic [2:0]  st;
  } token_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic [1:0]  in_tuser = CMD_DIGIT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  rpn_stack_evaluator_core #(.STACK_DEPTH(STACK_N)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // evaluator state mirrored by the bench
  logic [31:0] opstack [STACK_N];
  int unsigned depth = 0;
  logic [2:0]  err = ST_OK;

  answer_t    answer_q [$];
  answer_t    want;
  token_row_t plan [$];

  int  errors = 0;
  int  live_tokens = 0;
  int  words_seen = 0;
  int  status_seen [6] = '{default: 0};
  int  hold_cnt = 0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;
  bit  pin_valid = 1'b0;
  answer_t pin_answer;

  function automatic bit eval_token(input logic [1:0] cmd, input logic [3:0] dig,
                                    input logic [1:0] opc, output answer_t ans);
    logic [31:0] l, r, res, lm, rm, q;
    ans = '0;
    if (cmd == CMD_END) begin
      ans.st = err;
      if (err == ST_OK) begin
        if (depth == 1) ans.val = opstack[0];
        else ans.st = ST_COUNT;
      end
      depth = 0;
      err = ST_OK;
      return 1'b1;
    end
    if (err != ST_OK) return 1'b0;
    case (cmd)
      CMD_DIGIT: begin
        if (dig > DIGIT_MAX) err = ST_INVALID;
        else if (depth >= STACK_N) err = ST_OVERFLOW;
        else begin
          opstack[SAW'(depth)] = {28'd0, dig};
          depth++;
        end
      end
      CMD_OPER: begin
        if (depth < 2) begin
          err = ST_UNDERFLOW;
        end else begin
          r = opstack[SAW'(depth - 1)];
          l = opstack[SAW'(depth - 2)];
          res = '0;
          case (opc)
            OP_ADD: res = l + r;
            OP_SUB: res = l - r;
            OP_MUL: res = l * r;
            default: begin
              // truncating divide on magnitudes; min / -1 wraps to min
              lm = l[31] ? (32'd0 - l) : l;
              rm = r[31] ? (32'd0 - r) : r;
              if (r != 0) begin
                q = lm / rm;
                res = (l[31] ^ r[31]) ? (32'd0 - q) : q;
              end
            end
          endcase
          if (opc == OP_DIV && r == 0) begin
            err = ST_DIV_ZERO;
          end else begin
            depth--;
            opstack[SAW'(depth - 1)] = res;
          end
        end
      end
      default: err = ST_INVALID;
    endcase
    return 1'b0;
  endfunction

  function automatic token_row_t row(input logic [1:0] c, input logic [3:0] d,
                                     input logic [1:0] o, input logic p,
                                     input logic [31:0] v, input logic [2:0] s);
    row = '{cmd: c, dig: d, opc: o, pin: p, val: v, st: s};
  endfunction

  // accepted words on both sides
  always @(posedge clk) begin
    answer_t ans;
    if (rst_n && in_tvalid && in_tready) begin
      live_tokens++;
      if (eval_token(in_tuser, in_tdata[3:0], in_tdata[5:4], ans))
        answer_q.push_back(pin_valid ? pin_answer : ans);
    end
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (out_tuser < 6) status_seen[out_tuser]++;
      if (answer_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: value %0d status %0d",
                 $time, $signed(out_tdata), out_tuser);
      end else begin
        want = answer_q.pop_front();
        if (out_tdata !== want.val) begin
          errors++;
          $display("%0t: result_value expected %0d got %0d", $time,
                   $signed(want.val), $signed(out_tdata));
        end
        if (out_tuser !== want.st) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.st, out_tuser);
        end
      end
      if ($urandom_range(0, 15) == 0) out_quiet = ~out_quiet;
      hold_cnt = out_quiet ? 0 : $urandom_range(0, 15);
    end
  end

  // receiver stall after each result word
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [3:0] dig,
                           input logic [1:0] opc);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, opc, dig};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    token_row_t tok;
    int pick, noise, operands, pushed, cnt, n;

    // directed tokens
    plan.push_back(row(CMD_END,     4'd0,  OP_ADD, 1'b1, 32'd0, ST_COUNT));
    plan.push_back(row(CMD_DIGIT,   4'd9,  OP_DIV, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_END,     4'd15, OP_DIV, 1'b1, 32'd9, ST_OK));
    plan.push_back(row(CMD_DIGIT,   4'd3,  OP_ADD, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_DIGIT,   4'd4,  OP_SUB, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_OPER,    4'd0,  OP_ADD, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_DIGIT,   4'd6,  OP_MUL, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_OPER,    4'd15, OP_MUL, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_DIGIT,   4'd7,  OP_DIV, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_OPER,    4'd5,  OP_SUB, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_DIGIT,   4'd2,  OP_ADD, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_OPER,    4'd10, OP_DIV, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_END,     4'd0,  OP_ADD, 1'b0, 32'd0, ST_OK));
    // operator on an empty stack, then a digit that must be ignored
    plan.push_back(row(CMD_OPER,    4'd0,  OP_ADD, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_DIGIT,   4'd5,  OP_ADD, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_END,     4'd0,  OP_ADD, 1'b1, 32'd0, ST_UNDERFLOW));
    plan.push_back(row(CMD_DIGIT,   4'd4,  OP_ADD, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_DIGIT,   4'd0,  OP_ADD, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_OPER,    4'd0,  OP_DIV, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_END,     4'd0,  OP_ADD, 1'b1, 32'd0, ST_DIV_ZERO));
    // digit field above nine
    plan.push_back(row(CMD_DIGIT,   4'd15, OP_DIV, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_END,     4'd0,  OP_ADD, 1'b1, 32'd0, ST_INVALID));
    plan.push_back(row(CMD_INVALID, 4'd9,  OP_MUL, 1'b0, 32'd0, ST_OK));
    plan.push_back(row(CMD_END,     4'd0,  OP_ADD, 1'b1, 32'd0, ST_INVALID));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      tok = plan[i];
      pin_valid = tok.pin;
      pin_answer = '{val: tok.val, st: tok.st};
      send_word(tok.cmd, tok.dig, tok.opc);
      pin_valid = 1'b0;
    end

    while (live_tokens < TOKEN_GOAL) begin
      in_quiet = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // fill to around capacity, then fold back down
        n = $urandom_range(STACK_N - 2, STACK_N + 2);
        repeat (n) send_word(CMD_DIGIT, 4'($urandom_range(0, 9)), 2'($urandom_range(0, 3)));
        repeat (n - 1) send_word(CMD_OPER, 4'($urandom_range(0, 15)),
                                 2'($urandom_range(0, 2)));
        send_word(CMD_END, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      end else if (pick < 6) begin
        // 8^10 * 2 wraps to the most negative value, then divide by -1 or -2
        send_word(CMD_DIGIT, 4'd8, 2'($urandom_range(0, 3)));
        repeat (9) begin
          send_word(CMD_DIGIT, 4'd8, 2'($urandom_range(0, 3)));
          send_word(CMD_OPER, 4'($urandom_range(0, 15)), OP_MUL);
        end
        send_word(CMD_DIGIT, 4'd2, 2'($urandom_range(0, 3)));
        send_word(CMD_OPER, 4'($urandom_range(0, 15)), OP_MUL);
        send_word(CMD_DIGIT, 4'd0, 2'($urandom_range(0, 3)));
        send_word(CMD_DIGIT, 4'($urandom_range(1, 2)), 2'($urandom_range(0, 3)));
        send_word(CMD_OPER, 4'($urandom_range(0, 15)), OP_SUB);
        send_word(CMD_OPER, 4'($urandom_range(0, 15)), OP_DIV);
        send_word(CMD_END, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      end else begin
        // random well-formed expression, one in five salted with junk words
        noise = ($urandom_range(0, 4) == 0) ? 15 : 0;
        operands = $urandom_range(0, 8);
        pushed = 0;
        cnt = 0;
        while (pushed < operands || cnt > 1) begin
          if (noise != 0 && $urandom_range(0, 99) < noise)
            send_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
          if (pushed < operands && (cnt < 2 || $urandom_range(0, 1) == 1)) begin
            send_word(CMD_DIGIT, 4'($urandom_range(0, 9)), 2'($urandom_range(0, 3)));
            pushed++;
            cnt++;
          end else begin
            send_word(CMD_OPER, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
            cnt--;
          end
        end
        send_word(CMD_END, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      end
    end
    in_tvalid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d tokens, checked %0d result words.", live_tokens, words_seen);
    $display("Status mix: ok %0d, underflow %0d, div-zero %0d, invalid %0d, count %0d, overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d result words still outstanding", answer_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
